/* rtl/fwos_pkg.sv */
// Package for the FIFO with occupancy statistics: sizes, field structs,
// status and operation codes. No dependencies.
`default_nettype none

package fwos_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int TIME_WIDTH = 32;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 7;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int PROD_W = TIME_WIDTH + CNT_W;
   localparam int AREA_W = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                  op;
      logic [TIME_WIDTH-1:0] event_time;
      logic [DATA_WIDTH-1:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] payload_out;
      logic [1:0]            status;
      logic [CNT_W-1:0]      occupancy;
      logic [CNT_W-1:0]      max_occupancy;
      logic [AREA_W-1:0]     area_sum;
      logic [TIME_WIDTH-1:0] time_sum;
   } rsp_type;

   // Control from the sequencer to the ring store.
   typedef struct packed {
      logic rd_en;
      logic push;
      logic pop;
   } ring_cmd_type;

endpackage

`default_nettype wire

/* rtl/fwos_ring.sv */
// Circular ring store with head/tail indices and item count.
// Depends on fwos_pkg.
`default_nettype none

module fwos_ring
   import fwos_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ring_cmd_type          cmd,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   output logic      [CNT_W-1:0]      count,
   output logic      [DATA_WIDTH-1:0] head_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] head_ff;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_idx_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         head_ff <= mem[rd_idx_ff];
      end
   end

   always_comb begin
      rd_idx_in = cmd.pop  ? next_slot(rd_idx_ff) : rd_idx_ff;
      wr_idx_in = cmd.push ? next_slot(wr_idx_ff) : wr_idx_ff;
      count_in  = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         count_ff  <= count_in;
      end
   end

   assign count     = count_ff;
   assign head_data = head_ff;

endmodule

`default_nettype wire

/* rtl/fifo_with_occupancy_statistics_core.sv */
// Top level of the FIFO with time-weighted occupancy statistics.
// Depends on fwos_pkg and fwos_ring.
`default_nettype none

// Payload FIFO that also keeps a time-weighted occupancy record. Each request
// beat is an enqueue or a dequeue carrying a timestamp. Before the operation
// acts, the ticks elapsed since the previous beat (zero if time ran backward)
// times the current item count go into a 64-bit saturating area sum, and the
// elapsed ticks go into a saturating time sum. An enqueue is refused with
// FULL once the queue holds capacity minus one items; a dequeue on an empty
// queue returns EMPTY with a zero payload. Every request beat yields exactly
// one response beat. A beat steps through accept with delta and head read,
// multiply of delta by count, and saturating accumulate and commit, and the
// block takes no new request until that beat has committed; the next
// request is accepted while the previous response still waits in the output
// register, and only a response that cannot be handed off stalls the
// accumulate step. The items live in a single-port-read synchronous memory
// read at accept, ahead of the commit. csr_wr_data sets the capacity (reset
// 64, clamped to 2..64); write it only while the block is idle.
module fifo_with_occupancy_statistics_core
   import fwos_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_ACC  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration and statistics state.
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [CNT_W-1:0]      peak_ff, peak_in;
   logic [AREA_W-1:0]     area_ff, area_in;
   logic [TIME_WIDTH-1:0] tsum_ff, tsum_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;

   // Per-beat working registers.
   req_type               item_ff;
   logic [TIME_WIDTH-1:0] delta_ff;
   logic                  full_ff;
   logic                  empty_ff;
   logic [PROD_W-1:0]     prod_ff;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   ring_cmd_type          ring_cmd;
   logic [CNT_W-1:0]      count;
   logic [DATA_WIDTH-1:0] head_data;

   logic                  accept;
   logic                  commit;
   logic [CMP_W-1:0]      cap_eff;
   logic [CMP_W-1:0]      full_limit;
   logic [TIME_WIDTH-1:0] delta;
   logic [AREA_W:0]       area_sum;
   logic [TIME_WIDTH:0]   tsum_sum;
   logic                  push_ok;
   logic                  pop_ok;
   logic [CNT_W-1:0]      count_after;
   rsp_type               rsp_next;

   fwos_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ring_cmd),
      .wr_data   (item_ff.payload_in),
      .count     (count),
      .head_data (head_data)
   );

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign commit = (state_ff == ST_ACC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      // Clamp the capacity into 2..DEPTH; full at one below it.
      if (CMP_W'(cap_ff) < CMP_W'(2)) begin
         cap_eff = CMP_W'(2);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
      full_limit = cap_eff - CMP_W'(1);

      delta = (req_data.event_time >= last_ff) ? req_data.event_time - last_ff : '0;

      area_sum = {1'b0, area_ff} + (AREA_W + 1)'(prod_ff);
      tsum_sum = {1'b0, tsum_ff} + {1'b0, delta_ff};

      push_ok = (item_ff.op == OP_ENQ) && !full_ff;
      pop_ok  = (item_ff.op == OP_DEQ) && !empty_ff;

      count_after = count;
      if (push_ok) begin
         count_after = count + CNT_W'(1);
      end else if (pop_ok) begin
         count_after = count - CNT_W'(1);
      end

      ring_cmd.rd_en = accept;
      ring_cmd.push  = commit && push_ok;
      ring_cmd.pop   = commit && pop_ok;
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      peak_in      = peak_ff;
      area_in      = area_ff;
      tsum_in      = tsum_ff;
      last_in      = accept ? req_data.event_time : last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      rsp_next.payload_out = pop_ok ? head_data : '0;
      if (item_ff.op == OP_ENQ) begin
         rsp_next.status = full_ff ? STATUS_FULL : STATUS_OK;
      end else begin
         rsp_next.status = empty_ff ? STATUS_EMPTY : STATUS_OK;
      end
      rsp_next.occupancy     = count_after;
      rsp_next.max_occupancy = peak_ff;
      rsp_next.area_sum      = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
      rsp_next.time_sum      = tsum_sum[TIME_WIDTH] ? '1 : tsum_sum[TIME_WIDTH-1:0];
      // Track the peak after any enqueue, refused or not.
      if ((item_ff.op == OP_ENQ) && (count_after > peak_ff)) begin
         rsp_next.max_occupancy = count_after;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               peak_in      = rsp_next.max_occupancy;
               area_in      = rsp_next.area_sum;
               tsum_in      = rsp_next.time_sum;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         peak_ff      <= '0;
         area_ff      <= '0;
         tsum_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         peak_ff      <= peak_in;
         area_ff      <= area_in;
         tsum_ff      <= tsum_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers: hold the beat, its delta and flags, then the product.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff  <= req_data;
         delta_ff <= delta;
         full_ff  <= CMP_W'(count) >= full_limit;
         empty_ff <= (count == '0);
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(delta_ff) * PROD_W'(count);
      end
      if (commit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
